// ----- design/cbrb_pkg.sv -----
// Shared types and constants for the clipped bitmap row blit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package cbrb_pkg;

  localparam int X_W       = 12;
  localparam int Y_W       = 12;
  localparam int RIDX_W    = 8;
  localparam int HGT_W     = 9;
  localparam int BITS_W    = 32;
  localparam int ADDR_W    = 17;
  localparam int DIM_W     = 12;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SPRITE_ROWS   = 256;
  localparam int MAX_SCREEN_PIXELS = 2048;

  localparam logic [DIM_W-1:0]  RST_FB_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]  RST_FB_HEIGHT = 12'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_MODE = 2'd0,
    CFG_FB_WIDTH  = 2'd1,
    CFG_FB_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    WMODE_8  = 2'd0,
    WMODE_16 = 2'd1,
    WMODE_32 = 2'd2
  } wmode_t;

  typedef struct packed {
    logic [MODE_W-1:0] word_mode;
    logic [DIM_W-1:0]  fb_width;
    logic [DIM_W-1:0]  fb_height;
  } cfg_t;

  // Writes caused by the row held in the input register.
  typedef struct packed {
    logic              busy;
    logic [1:0]        n_wr;
    logic [ADDR_W-1:0] addr0;
    logic [BITS_W-1:0] data0;
    logic [ADDR_W-1:0] addr1;
    logic [BITS_W-1:0] data1;
  } plan_t;

endpackage

// ----- design/cbrb_cfg.sv -----
// Configuration registers of the bitmap row blit.
// Depends on cbrb_pkg.
`timescale 1ns / 1ps
module cbrb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbrb_pkg::DIM_W-1:0]    cfg_data,
  output cbrb_pkg::cfg_t                cfg
);
  import cbrb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WORD_MODE: cfg_nxt.word_mode = cfg_data[MODE_W-1:0];
        CFG_FB_WIDTH:  cfg_nxt.fb_width  = cfg_data;
        CFG_FB_HEIGHT: cfg_nxt.fb_height = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.word_mode <= WMODE_8;
      cfg_r.fb_width  <= RST_FB_WIDTH;
      cfg_r.fb_height <= RST_FB_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/cbrb_calc.sv -----
// Input register and the clipping, address and shift logic behind it.
// Depends on cbrb_pkg.
`timescale 1ns / 1ps
module cbrb_calc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cbrb_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cbrb_pkg::X_W-1:0]    in_sprite_x,
  input  logic [cbrb_pkg::Y_W-1:0]    in_sprite_y,
  input  logic [cbrb_pkg::RIDX_W-1:0] in_row_index,
  input  logic [cbrb_pkg::HGT_W-1:0]  in_sprite_height,
  input  logic [cbrb_pkg::BITS_W-1:0] in_row_bits,
  input  logic                        advance,
  output cbrb_pkg::plan_t             plan
);
  import cbrb_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [X_W-1:0]    x_r;
  logic [Y_W-1:0]    y_r;
  logic [RIDX_W-1:0] ridx_r;
  logic [HGT_W-1:0]  hgt_r;
  logic [BITS_W-1:0] bits_r;
  logic              in_fire;

  logic [2:0]        wshift;
  logic [5:0]        wbits;
  logic [BITS_W-1:0] wmask;
  logic [BITS_W-1:0] bits;
  logic [DIM_W-1:0]  width;
  logic [DIM_W-1:0]  sheight;
  logic [HGT_W-1:0]  hclamp;
  logic signed [Y_W:0] line;
  logic signed [X_W:0] x_ext;
  logic signed [X_W:0] neg_w;
  logic              row_ok;
  logic              col_ok;
  logic [8:0]        per_line;
  logic [19:0]       prod;
  logic [X_W-1:0]    neg_x;
  logic [X_W-2:0]    col;
  logic [4:0]        s;
  logic [5:0]        rshift;
  logic [ADDR_W-1:0] base;

  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r    <= in_sprite_x;
      y_r    <= in_sprite_y;
      ridx_r <= in_row_index;
      hgt_r  <= in_sprite_height;
      bits_r <= in_row_bits;
    end
  end

  always_comb begin
    case (cfg.word_mode)
      WMODE_8:  wshift = 3'd3;
      WMODE_16: wshift = 3'd4;
      default:  wshift = 3'd5;
    endcase
    wbits = 6'd1 << wshift;
    wmask = (wshift == 3'd5) ? {BITS_W{1'b1}} : ((BITS_W'(1) << wbits) - BITS_W'(1));
    bits  = bits_r & wmask;

    width = {cfg.fb_width[DIM_W-1:5], 5'b0};
    if (width > DIM_W'(MAX_SCREEN_PIXELS)) begin
      width = DIM_W'(MAX_SCREEN_PIXELS);
    end
    sheight = cfg.fb_height;
    if (sheight > DIM_W'(MAX_SCREEN_PIXELS)) begin
      sheight = DIM_W'(MAX_SCREEN_PIXELS);
    end
    hclamp = hgt_r;
    if (hclamp > HGT_W'(MAX_SPRITE_ROWS)) begin
      hclamp = HGT_W'(MAX_SPRITE_ROWS);
    end

    line   = $signed({y_r[Y_W-1], y_r}) + $signed({5'b0, ridx_r});
    row_ok = ({1'b0, ridx_r} < hclamp) && !line[Y_W]
             && (line[Y_W-1:0] < sheight);

    x_ext  = $signed({x_r[X_W-1], x_r});
    neg_w  = $signed(13'd0) - $signed({7'b0, wbits});
    col_ok = (x_ext > neg_w) && !(!x_r[X_W-1] && (x_r >= width));

    per_line = 9'(width >> wshift);
    prod     = 20'(line[10:0] * per_line);
    neg_x    = X_W'(0) - x_r;
    col      = x_r[X_W-2:0] >> wshift;
    s        = x_r[4:0] & 5'(wbits - 6'd1);
    rshift   = wbits - {1'b0, s};
    base     = ADDR_W'(prod) + ADDR_W'(col);

    plan.busy  = s1_valid_r;
    plan.n_wr  = 2'd0;
    plan.addr0 = base;
    plan.data0 = bits >> s;
    plan.addr1 = base + ADDR_W'(1);
    plan.data1 = (bits << rshift) & wmask;
    if (s1_valid_r && row_ok && col_ok) begin
      if (x_r[X_W-1]) begin
        // Clipped on the left: shift into word 0 of the line.
        plan.n_wr  = 2'd1;
        plan.addr0 = ADDR_W'(prod);
        plan.data0 = (bits << neg_x[4:0]) & wmask;
      end else if ((s != 5'd0) && ({1'b0, col} + 12'd1 < {3'b0, per_line})) begin
        plan.n_wr = 2'd2;
      end else begin
        plan.n_wr = 2'd1;
      end
    end
  end

endmodule

// ----- design/cbrb_out.sv -----
// Result register with one pending slot for the second word of a split row.
// Depends on cbrb_pkg.
`timescale 1ns / 1ps
module cbrb_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cbrb_pkg::plan_t             plan,
  output logic                        advance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cbrb_pkg::ADDR_W-1:0] out_word_address,
  output logic [cbrb_pkg::BITS_W-1:0] out_or_data,
  output logic                        out_last_write
);
  import cbrb_pkg::*;

  logic              o_valid_r, o_valid_nxt;
  logic              p_valid_r, p_valid_nxt;
  logic [ADDR_W-1:0] o_addr_r, o_addr_nxt, p_addr_r, p_addr_nxt;
  logic [BITS_W-1:0] o_data_r, o_data_nxt, p_data_r, p_data_nxt;
  logic              o_last_r, o_last_nxt;
  logic              out_fire;
  logic              room;
  logic              load;

  assign out_fire = o_valid_r && !out_stall;
  assign room     = !o_valid_r || (out_fire && !p_valid_r);
  // A row that writes nothing may always leave.
  assign advance  = plan.busy && ((plan.n_wr == 2'd0) || room);
  assign load     = advance && (plan.n_wr != 2'd0);

  always_comb begin
    o_valid_nxt = o_valid_r;
    p_valid_nxt = p_valid_r;
    o_addr_nxt  = o_addr_r;
    o_data_nxt  = o_data_r;
    o_last_nxt  = o_last_r;
    p_addr_nxt  = p_addr_r;
    p_data_nxt  = p_data_r;
    if (out_fire && p_valid_r) begin
      o_valid_nxt = 1'b1;
      o_addr_nxt  = p_addr_r;
      o_data_nxt  = p_data_r;
      o_last_nxt  = 1'b1;
      p_valid_nxt = 1'b0;
    end else if (load) begin
      o_valid_nxt = 1'b1;
      o_addr_nxt  = plan.addr0;
      o_data_nxt  = plan.data0;
      o_last_nxt  = (plan.n_wr == 2'd1);
      p_valid_nxt = (plan.n_wr == 2'd2);
      p_addr_nxt  = plan.addr1;
      p_data_nxt  = plan.data1;
    end else if (out_fire) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
      p_valid_r <= 1'b0;
    end else begin
      o_valid_r <= o_valid_nxt;
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_addr_r <= o_addr_nxt;
    o_data_r <= o_data_nxt;
    o_last_r <= o_last_nxt;
    p_addr_r <= p_addr_nxt;
    p_data_r <= p_data_nxt;
  end

  assign out_valid        = o_valid_r;
  assign out_word_address = o_addr_r;
  assign out_or_data      = o_data_r;
  assign out_last_write   = o_last_r;

endmodule

// ----- design/clipped_bitmap_row_or_blit.sv -----
// Top level of the clipped monochrome bitmap row blit.
// Depends on cbrb_pkg, cbrb_cfg, cbrb_calc and cbrb_out.
//
// Usage:
//   Input channel (in_valid / in_stall): one beat is one sprite row with its
//   position, row number, sprite height and pixel bits.
//   Output channel (out_valid / out_stall): one beat is one framebuffer
//   OR-write; out_last_write marks the final write of a row. A row gives
//   zero, one or two writes.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//   word mode, screen width and height only while the block is idle.
// Path: a row accepted into the input register has its first write loaded
//   into the result register when there is room, which drives the output port.
// Throughput: one row per cycle for rows giving zero or one write while out_stall
//   is low; a row split over two words holds the single port for both writes.
// Reset (synchronous, rst_n low): empties the input and result registers and
//   loads 8-bit words, width 640 and height 400.
// Output stall: the write on the port holds; the input register keeps taking
//   rows until it holds one that cannot move on, then in_stall rises.
`timescale 1ns / 1ps
module clipped_bitmap_row_or_blit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbrb_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbrb_pkg::X_W-1:0]       in_sprite_x,
  input  logic [cbrb_pkg::Y_W-1:0]       in_sprite_y,
  input  logic [cbrb_pkg::RIDX_W-1:0]    in_row_index,
  input  logic [cbrb_pkg::HGT_W-1:0]     in_sprite_height,
  input  logic [cbrb_pkg::BITS_W-1:0]    in_row_bits,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbrb_pkg::ADDR_W-1:0]    out_word_address,
  output logic [cbrb_pkg::BITS_W-1:0]    out_or_data,
  output logic                           out_last_write
);
  import cbrb_pkg::*;

  cfg_t  cfg;
  plan_t plan;
  logic  advance;

  cbrb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbrb_calc u_calc (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sprite_x      (in_sprite_x),
    .in_sprite_y      (in_sprite_y),
    .in_row_index     (in_row_index),
    .in_sprite_height (in_sprite_height),
    .in_row_bits      (in_row_bits),
    .advance          (advance),
    .plan             (plan)
  );

  cbrb_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .plan             (plan),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_address (out_word_address),
    .out_or_data      (out_or_data),
    .out_last_write   (out_last_write)
  );

endmodule

// ----- design/cbrb_chk.sv -----
// Port-level checks for the bitmap row blit, bound to the top level.
// Depends on cbrb_pkg and clipped_bitmap_row_or_blit.
`timescale 1ns / 1ps
module cbrb_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cbrb_pkg::ADDR_W-1:0]    out_word_address,
  input logic [cbrb_pkg::BITS_W-1:0]    out_or_data,
  input logic                           out_last_write
);
  import cbrb_pkg::*;

  // A stalled write holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_address)
      && $stable(out_or_data) && $stable(out_last_write))
    else $error("stalled output beat changed");

  // The first half of a split row is followed at once by the next word.
  a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_write |=> out_valid && out_last_write
      && (out_word_address == $past(out_word_address) + ADDR_W'(1)))
    else $error("split row second write missing or misplaced");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind clipped_bitmap_row_or_blit cbrb_chk u_cbrb_chk (.*);

// ----- tb/testbench.sv -----
// Self-checking bench for clipped_bitmap_row_or_blit: sprite rows in, framebuffer OR-writes out.
// Predicts each row's writes from the current register settings and checks them in order.
// Depends on cbrb_pkg and the design top level.
`timescale 1ns / 1ps
module testbench;
  import cbrb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [RIDX_W-1:0] ridx;
    logic [HGT_W-1:0]  height;
    logic [BITS_W-1:0] bits;
  } blit_row_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BITS_W-1:0] data;
    logic              last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WORD_MODE;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_W-1:0] out_word_address;
  logic [BITS_W-1:0] out_or_data;
  logic out_last_write;
  blit_row_t cur_row = '0;

  // Settings as the block holds them
  logic [MODE_W-1:0] cur_mode = WMODE_8;
  logic [DIM_W-1:0] cur_width = RST_FB_WIDTH;
  logic [DIM_W-1:0] cur_height = RST_FB_HEIGHT;

  blit_row_t queued_rows[$];
  fb_write_t expected_writes[$];
  int rows_queued = 0;
  int rows_taken = 0;
  int gap_left = 0;
  int stall_left = 0;
  int failures = 0;
  int cycles = 0;
  bit steady_flow = 1'b0;

  always #4 clk = ~clk;

  clipped_bitmap_row_or_blit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sprite_x      (cur_row.x),
    .in_sprite_y      (cur_row.y),
    .in_row_index     (cur_row.ridx),
    .in_sprite_height (cur_row.height),
    .in_row_bits      (cur_row.bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_address (out_word_address),
    .out_or_data      (out_or_data),
    .out_last_write   (out_last_write)
  );

  function automatic int word_bits();
    case (cur_mode)
      WMODE_8:  return 8;
      WMODE_16: return 16;
      default:  return 32;
    endcase
  endfunction

  function automatic int eff_width();
    int w;
    w = int'(cur_width) & ~31;
    return (w > MAX_SCREEN_PIXELS) ? MAX_SCREEN_PIXELS : w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(cur_height);
    return (h > MAX_SCREEN_PIXELS) ? MAX_SCREEN_PIXELS : h;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic void queue_write(logic [ADDR_W-1:0] addr, logic [63:0] data, logic last);
    expected_writes.push_back('{addr, data[BITS_W-1:0], last});
  endfunction

  // Work out the OR-writes that one accepted row causes
  function automatic void plan_or_writes(blit_row_t r);
    int wb, width, sh, hgt, x, y, line, per_line, col, s;
    logic [63:0] bits, wmask;
    logic [ADDR_W-1:0] base;
    wb = word_bits();
    wmask = (64'd1 << wb) - 64'd1;
    bits = {32'd0, r.bits} & wmask;
    width = eff_width();
    sh = eff_height();
    hgt = (r.height > MAX_SPRITE_ROWS) ? MAX_SPRITE_ROWS : int'(r.height);
    x = $signed(r.x);
    y = $signed(r.y);
    line = y + int'(r.ridx);
    if (int'(r.ridx) >= hgt || line < 0 || line >= sh) return;
    if (x <= -wb || x >= width) return;
    per_line = width / wb;
    if (x < 0) begin
      base = ADDR_W'(line * per_line);
      queue_write(base, (bits << -x) & wmask, 1'b1);
      return;
    end
    col = x / wb;
    s = x % wb;
    base = ADDR_W'(line * per_line + col);
    if (s != 0 && col < per_line - 1) begin
      queue_write(base, bits >> s, 1'b0);
      queue_write(base + ADDR_W'(1), (bits << (wb - s)) & wmask, 1'b1);
    end else begin
      queue_write(base, bits >> s, 1'b1);
    end
  endfunction

  function automatic void add_row(int x, int y, int ridx, int h, logic [BITS_W-1:0] bits);
    queued_rows.push_back('{x[X_W-1:0], y[Y_W-1:0], ridx[RIDX_W-1:0], h[HGT_W-1:0], bits});
    rows_queued++;
  endfunction

  // Mostly rows that land on or near the screen, some anywhere at all
  function automatic void add_random(int n);
    int wb, ridx, h, line, x;
    logic [BITS_W-1:0] bits;
    repeat (n) begin
      wb = word_bits();
      ridx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 8) begin
        h = $urandom_range(ridx + 1, MAX_SPRITE_ROWS);
        line = $urandom_range(0, eff_height() + 3) - 2;
        x = $urandom_range(0, eff_width() + 2 * wb) - wb;
      end else begin
        h = $urandom_range(0, 511);
        line = $urandom_range(0, 4095) - 2048;
        x = $urandom_range(0, 4095) - 2048;
      end
      case ($urandom_range(0, 7))
        0:       bits = '1;
        1:       bits = '0;
        2:       bits = 32'd1 << $urandom_range(0, 31);
        default: bits = $urandom;
      endcase
      add_row(x, line - ridx, ridx, h, bits);
    end
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Write all three registers back to back, valid held high across them
  task automatic write_config(int mode, int width, int height);
    cfg_idx_t idxs[3];
    int vals[3];
    idxs = '{CFG_WORD_MODE, CFG_FB_WIDTH, CFG_FB_HEIGHT};
    vals = '{mode, width, height};
    @(posedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idxs[i];
      cfg_data <= vals[i][DIM_W-1:0];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_mode = mode[MODE_W-1:0];
    cur_width = width[DIM_W-1:0];
    cur_height = height[DIM_W-1:0];
  endtask

  // Hold the sender until every row is in and every write is out
  task automatic wait_drain();
    do @(posedge clk); while (rows_taken != rows_queued || expected_writes.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  always @(posedge clk) begin
    blit_row_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        plan_or_writes(cur_row);
        rows_taken++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_rows.size() != 0) begin
        nxt = queued_rows.pop_front();
        cur_row <= nxt;
        in_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    fb_write_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_writes.size() == 0) begin
        note_failure($sformatf("unexpected write addr %0d data %h last %0b",
                               out_word_address, out_or_data, out_last_write));
      end else begin
        want = expected_writes.pop_front();
        if (out_word_address !== want.addr || out_or_data !== want.data ||
            out_last_write !== want.last)
          note_failure($sformatf("expected addr %0d data %h last %0b, got addr %0d data %h last %0b",
                                 want.addr, want.data, want.last,
                                 out_word_address, out_or_data, out_last_write));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 8-bit words, 80 words per line, 400 lines
    add_row(0, 0, 0, 1, 32'h0000_00ff);
    add_row(3, 10, 2, 4, 32'h0000_00a5);
    add_row(637, 0, 0, 1, 32'h0000_00c3);
    add_row(639, 5, 0, 1, 32'h0000_00ff);
    add_row(-3, 7, 0, 1, 32'h0000_00b7);
    add_row(-7, 7, 1, 2, 32'h0000_00ff);
    add_row(-8, 7, 0, 1, 32'h0000_00ff);
    add_row(640, 7, 0, 1, 32'h0000_00ff);
    add_row(2047, 0, 0, 1, 32'h0000_00ff);
    add_row(-2048, 0, 0, 1, 32'h0000_00ff);
    add_row(16, 0, 5, 5, 32'h0000_00ff);
    add_row(16, -3, 2, 8, 32'h0000_00ff);
    add_row(16, -3, 3, 8, 32'h0000_0081);
    add_row(24, 399, 0, 1, 32'h0000_0042);
    add_row(24, 400, 0, 1, 32'h0000_0042);
    add_row(8, 0, 0, 0, 32'h0000_00ff);
    add_row(8, 0, 255, 511, 32'h0000_00ff);
    add_row(8, 2047, 0, 1, 32'h0000_00ff);
    add_row(8, -2048, 255, 256, 32'h0000_00ff);
    add_row(4, 1, 0, 1, 32'hffff_ffff);
    add_row(12, 2, 0, 1, 32'h0000_0000);
    add_random(80);
    wait_drain();

    // Widest, tallest screen: addresses wrap past the top of the word space
    write_config(WMODE_16, 2048, 2048);
    add_row(0, 2047, 0, 1, 32'hffff_ffff);
    add_row(2040, 2000, 0, 1, 32'h0000_f00f);
    add_row(17, 1500, 0, 1, 32'h0000_abcd);
    add_random(40);
    wait_drain();
    add_random(40);
    wait_drain();

    // Narrowest screen, one line, one word per line
    write_config(WMODE_32, 32, 1);
    add_row(-5, 0, 0, 1, 32'hdead_beef);
    add_row(5, 0, 0, 1, 32'hdead_beef);
    add_row(0, 0, 0, 1, 32'h8000_0001);
    add_row(0, 1, 0, 1, 32'hffff_ffff);
    add_random(50);
    wait_drain();

    // Unused mode, oversized width and height
    write_config(3, 4095, 4095);
    add_row(2047, 100, 0, 1, 32'hffff_ffff);
    add_row(33, 2047, 0, 1, 32'h1234_5678);
    add_random(80);
    wait_drain();

    // Odd width and zero height: nothing lands
    write_config(WMODE_8, 50, 0);
    add_random(15);
    wait_drain();

    // Zero width: only left-clipped rows land
    write_config(WMODE_16, 0, 300);
    add_row(-4, 3, 0, 1, 32'h0000_ffff);
    add_row(0, 3, 0, 1, 32'h0000_ffff);
    add_random(25);
    wait_drain();

    for (int p = 0; p < 4; p++) begin
      steady_flow = (p == 2);
      write_config($urandom_range(0, 3), 32 * $urandom_range(1, 64), $urandom_range(1, 2048));
      add_random(60);
      wait_drain();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cbrb_pkg.sv
design/cbrb_cfg.sv
design/cbrb_calc.sv
design/cbrb_out.sv
design/clipped_bitmap_row_or_blit.sv
design/cbrb_chk.sv
tb/testbench.sv
